// File: hdl/nnsc_pkg.sv
`default_nettype none

package nnsc_pkg;

	// fixed field widths
	localparam int unsigned COORD_W = 12;
	localparam int unsigned CFG_W = 13;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned OUT_W = 14;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CURVE_W = 5;

	localparam int OUT_MAX = 8191;
	localparam int OUT_MIN = -8192;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WARP_MODE = 3'd4;

	// warp modes; the unused code behaves as plain
	localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CURVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;

	// curve shift stepping
	localparam logic [CURVE_W-1:0] CURVE_LIMIT = 5'd20;
	localparam logic [CURVE_W-1:0] CURVE_STEP = 5'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_DONE
	} state_t;

	// per-cycle commands from the sequencer to each coordinate lane
	typedef struct packed {
		logic load;
		logic mul;
		logic prep;
		logic div;
		logic fin1;
		logic fin2;
		logic fin3;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/nnsc_lane.sv
`default_nettype none

// One coordinate: bit-serial multiply, signed numerator, bit-serial restoring
// divide, floor, offset, floor-to-trunc correction, saturation and range check.
module nnsc_lane import nnsc_pkg::*; #(
	parameter int unsigned FW = 14,
	parameter int unsigned DW = 13,
	parameter int unsigned DNW = 15
) (
	input  wire logic                    clk,
	input  wire lane_ctrl_t              ctrl,
	input  wire logic [COORD_W-1:0]      coord,
	input  wire logic [FW-1:0]           fac_mag,
	input  wire logic                    fac_neg,
	input  wire logic                    mirror,
	input  wire logic [DNW-1:0]          den,
	input  wire logic [DNW-1:0]          cadd,
	input  wire logic [DW-1:0]           offset,
	input  wire logic [DW-1:0]           lim,
	output logic signed [OUT_W-1:0]      src,
	output logic                         in_range
);

	localparam int unsigned PW = COORD_W + FW;
	localparam int unsigned NW = PW + 2;
	localparam int unsigned VW = NW + 2;
	localparam logic signed [VW-1:0] SAT_HI = VW'(OUT_MAX);
	localparam logic signed [VW-1:0] SAT_LO = VW'(OUT_MIN);

	logic [COORD_W-1:0]     coord_q;
	logic [FW-1:0]          fac_q;
	logic                   neg_q;
	logic [DNW-1:0]         den_q;
	logic [DNW-1:0]         c_q;
	logic [DW-1:0]          off_q;
	logic [DW-1:0]          lim_q;
	logic [PW-1:0]          acc_q;
	logic [NW-1:0]          num_q;
	logic [DNW-1:0]         rem_q;
	logic                   nneg_q;
	logic                   remnz_q;
	logic signed [VW-1:0]   floor_q;
	logic signed [VW-1:0]   v_q;
	logic signed [VW-1:0]   vt_q;

	// numerator build: (neg ? c - 2P : 2P + c), split into magnitude and sign
	logic [NW-1:0] p2, ce, n_sum, n_pc, n_cp, n_mag;
	logic          n_gt, n_neg;

	always_comb begin
		p2 = NW'({acc_q, 1'b0});
		ce = NW'(c_q);
		n_sum = p2 + ce;
		n_pc = p2 - ce;
		n_cp = ce - p2;
		n_gt = p2 > ce;
		if (!neg_q) begin
			n_mag = n_sum;
			n_neg = 1'b0;
		end else if (n_gt) begin
			n_mag = n_pc;
			n_neg = 1'b1;
		end else begin
			n_mag = n_cp;
			n_neg = 1'b0;
		end
	end

	// one restoring divide step
	logic [DNW:0]   d_try, d_sub;
	logic           d_ge;
	logic [DNW-1:0] d_rem;

	always_comb begin
		d_try = {rem_q, num_q[NW-1]};
		d_sub = d_try - {1'b0, den_q};
		d_ge = d_try >= {1'b0, den_q};
		d_rem = d_ge ? d_sub[DNW-1:0] : d_try[DNW-1:0];
	end

	logic [VW-1:0] qe;
	assign qe = VW'(num_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			coord_q <= coord;
			fac_q <= fac_mag;
			neg_q <= fac_neg ^ mirror;
			den_q <= den;
			c_q <= cadd;
			off_q <= offset;
			lim_q <= lim;
			acc_q <= '0;
		end else if (ctrl.mul) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (coord_q[COORD_W-1] ? PW'(fac_q) : '0);
			coord_q <= {coord_q[COORD_W-2:0], 1'b0};
		end else if (ctrl.prep) begin
			num_q <= n_mag;
			nneg_q <= n_neg;
			rem_q <= '0;
		end else if (ctrl.div) begin
			rem_q <= d_rem;
			num_q <= {num_q[NW-2:0], d_ge};
		end else if (ctrl.fin1) begin
			// floor quotient: -q, less one when inexact
			remnz_q <= rem_q != '0;
			floor_q <= nneg_q ? (~qe + VW'(rem_q == '0)) : qe;
		end else if (ctrl.fin2) begin
			v_q <= floor_q + $signed(VW'(off_q));
		end else if (ctrl.fin3) begin
			// floor -> trunc toward zero
			vt_q <= (v_q[VW-1] && remnz_q) ? v_q + VW'(1) : v_q;
		end
	end

	always_comb begin
		if (vt_q > SAT_HI) begin
			src = SAT_HI[OUT_W-1:0];
		end else if (vt_q < SAT_LO) begin
			src = SAT_LO[OUT_W-1:0];
		end else begin
			src = vt_q[OUT_W-1:0];
		end
		in_range = !vt_q[VW-1] && (vt_q < $signed(VW'(lim_q)));
	end

endmodule

`default_nettype wire

// File: hdl/nearest_neighbor_scale_coordinates.sv
`default_nettype none

// Nearest-neighbor source coordinate generator. Feed output pixel coordinates
// (out_x, out_y) in raster order; each accepted word gives one result word with
// the rounded source column and row (exact rational quotient, rounded as
// trunc(v + 1/2)), an in-range flag and the write / reuse-last-color flags.
// warp_mode 0 scales plainly, 1 applies the row-varying curve warp to x,
// 2 mirrors the plain scale; code 3 acts as 0. Dimension registers holding 0
// count as 1 and values above MAX_DIM count as MAX_DIM. An input at (0,0)
// restarts the curve state in every mode. Write configuration only while idle.
// One word is in flight at a time; the next word is taken once the result of
// the last has been loaded into the output register.
// Time goes into a 12-step bit-serial multiply of the coordinate and an NW-step
// bit-serial restoring divide, both lanes (x and y) running side by side.
// A finished result sits in the output register and does not block the next
// input word.
module nearest_neighbor_scale_coordinates import nnsc_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_wr_en,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// input words
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_W-1:0]    out_x,
	input  wire logic [COORD_W-1:0]    out_y,
	// result words
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [OUT_W-1:0]    src_x,
	output logic signed [OUT_W-1:0]    src_y,
	output logic                       in_range,
	output logic                       write_pixel,
	output logic                       reuse_last_colour
);

	localparam int unsigned DW = $clog2(MAX_DIM + 1);
	localparam int unsigned FW = ((DW > COORD_W) ? DW : COORD_W) + 1;
	localparam int unsigned DNW = ((DW > 5) ? DW : 5) + 2;
	localparam int unsigned NW = COORD_W + FW + 2;
	localparam int unsigned CW = $clog2(NW);

	// configuration registers
	logic [CFG_W-1:0]  src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [MODE_W-1:0] warp_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= CFG_W'(1);
			src_height_q <= CFG_W'(1);
			dst_width_q <= CFG_W'(1);
			dst_height_q <= CFG_W'(1);
			warp_mode_q <= MODE_PLAIN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SRC_WIDTH: src_width_q <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_DST_WIDTH: dst_width_q <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				REG_WARP_MODE: warp_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DW'(MAX_DIM);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	logic [DW-1:0] sw, sh, dw, dh;
	logic          mode_curve, mode_mirror;

	assign sw = eff_dim(src_width_q);
	assign sh = eff_dim(src_height_q);
	assign dw = eff_dim(dst_width_q);
	assign dh = eff_dim(dst_height_q);
	assign mode_curve = warp_mode_q == MODE_CURVE;
	assign mode_mirror = warp_mode_q == MODE_MIRROR;

	// sequencer
	state_t        st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic          mul_last, div_last, out_free, accept;
	lane_ctrl_t    ctrl;

	assign mul_last = cnt_q == CW'(COORD_W - 1);
	assign div_last = cnt_q == CW'(NW - 1);
	assign out_free = !out_valid || !out_stall;
	assign accept = in_valid && !in_stall;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_valid) st_d = ST_MUL;
			ST_MUL: if (mul_last) st_d = ST_PREP;
			ST_PREP: st_d = ST_DIV;
			ST_DIV: if (div_last) st_d = ST_FIN1;
			ST_FIN1: st_d = ST_FIN2;
			ST_FIN2: st_d = ST_FIN3;
			ST_FIN3: st_d = ST_DONE;
			ST_DONE: if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = st_q != ST_IDLE;
		ctrl = '0;
		case (st_q)
			ST_IDLE: ctrl.load = in_valid;
			ST_MUL: ctrl.mul = 1'b1;
			ST_PREP: ctrl.prep = 1'b1;
			ST_DIV: ctrl.div = 1'b1;
			ST_FIN1: ctrl.fin1 = 1'b1;
			ST_FIN2: ctrl.fin2 = 1'b1;
			ST_FIN3: ctrl.fin3 = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if ((st_q == ST_MUL && !mul_last) || (st_q == ST_DIV && !div_last)) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// curve state: restart at (0,0), step after the row end of every 4th row
	logic [CURVE_W-1:0] curve_phase_q, curve_shift_q;
	logic               curve_rising_q;
	logic               restart, row_end;
	logic [CURVE_W-1:0] ph_base, sh_base, ph_inc, ph_d, sh_d;
	logic               ri_base, ri_d;

	assign restart = (out_x == '0) && (out_y == '0);
	assign row_end = mode_curve && (FW'(out_x) == FW'(dw) - FW'(1)) && (out_y[1:0] == 2'b00);

	always_comb begin
		ph_base = restart ? '0 : curve_phase_q;
		sh_base = restart ? '0 : curve_shift_q;
		ri_base = restart ? 1'b1 : curve_rising_q;
		ph_inc = ph_base + CURVE_STEP;
		ph_d = ph_base;
		sh_d = sh_base;
		ri_d = ri_base;
		if (row_end) begin
			sh_d = ri_base ? ph_inc : CURVE_LIMIT - ph_inc;
			if (ph_inc > CURVE_LIMIT - CURVE_W'(1)) begin
				ph_d = ph_inc - CURVE_LIMIT;
				ri_d = !ri_base;
			end else begin
				ph_d = ph_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_phase_q <= '0;
			curve_shift_q <= '0;
			curve_rising_q <= 1'b1;
		end else if (accept) begin
			curve_phase_q <= ph_d;
			curve_shift_q <= sh_d;
			curve_rising_q <= ri_d;
		end
	end

	// lane operands, taken at acceptance with the shift in force for this pixel
	logic [FW:0]    fx, fx_n;
	logic [FW-1:0]  fx_mag;
	logic           fx_neg;
	logic [DNW-1:0] den_x, c_x, den_y, c_y, den_curve;
	logic [DW-1:0]  off_x, off_y;

	always_comb begin
		fx = (FW + 1)'(sw) + (FW + 1)'(out_x) - (FW + 1)'(sh_base);
		fx_n = ~fx + (FW + 1)'(1);
		den_curve = DNW'({dw, 1'b0}) - DNW'(1) + DNW'(sh_base);
		if (mode_curve) begin
			fx_neg = fx[FW];
			fx_mag = fx[FW] ? fx_n[FW-1:0] : fx[FW-1:0];
			den_x = DNW'({den_curve, 1'b0});
			c_x = den_curve;
		end else begin
			fx_neg = 1'b0;
			fx_mag = FW'(sw);
			den_x = DNW'({dw, 1'b0});
			c_x = DNW'(dw);
		end
		den_y = DNW'({dh, 1'b0});
		c_y = DNW'(dh);
		off_x = mode_mirror ? dw - DW'(1) : '0;
		off_y = mode_mirror ? dh - DW'(1) : '0;
	end

	logic signed [OUT_W-1:0] lx_src, ly_src;
	logic                    lx_inr, ly_inr;

	nnsc_lane #(
		.FW(FW),
		.DW(DW),
		.DNW(DNW)
	) u_lane_x (
		.clk(clk),
		.ctrl(ctrl),
		.coord(out_x),
		.fac_mag(fx_mag),
		.fac_neg(fx_neg),
		.mirror(mode_mirror),
		.den(den_x),
		.cadd(c_x),
		.offset(off_x),
		.lim(sw),
		.src(lx_src),
		.in_range(lx_inr)
	);

	nnsc_lane #(
		.FW(FW),
		.DW(DW),
		.DNW(DNW)
	) u_lane_y (
		.clk(clk),
		.ctrl(ctrl),
		.coord(out_y),
		.fac_mag(FW'(sh)),
		.fac_neg(1'b0),
		.mirror(mode_mirror),
		.den(den_y),
		.cadd(c_y),
		.offset(off_y),
		.lim(sh),
		.src(ly_src),
		.in_range(ly_inr)
	);

	// mode of the word in flight
	logic curve_word_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			curve_word_q <= mode_curve;
		end
	end

	// output register
	logic out_load, inr;

	assign out_load = (st_q == ST_DONE) && out_free;
	assign inr = lx_inr && ly_inr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			src_x <= lx_src;
			src_y <= ly_src;
			in_range <= inr;
			write_pixel <= curve_word_q || inr;
			reuse_last_colour <= curve_word_q && !inr;
		end
	end

endmodule

`default_nettype wire

// File: tb/nearest_neighbor_scale_coordinates_test.sv
module nearest_neighbor_scale_coordinates_test import nnsc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = 4096;
	// spacing of words in flight at MAX_DIM = 4096
	localparam int LATENCY = 46;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 13;
	localparam int PHASE_WORDS = 100;
	localparam int PLAN_ROWS = 29;
	localparam time RUN_LIMIT = 20ms;

	// codes the package leaves unnamed
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CFG_W-1:0] dim_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] sx;
		logic signed [OUT_W-1:0] sy;
		logic inr;
		logic wr;
		logic reuse;
	} source_word_t;

	// one row of the directed plan: either a full register setup or one word,
	// the latter optionally with its result typed in
	typedef struct packed {
		logic setup;
		dim_t sw;
		dim_t sh;
		dim_t dw;
		dim_t dh;
		logic [MODE_W-1:0] mode;
		coord_t x;
		coord_t y;
		logic pinned;
		source_word_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	dim_t cfg_data;
	logic in_valid;
	logic in_stall;
	coord_t out_x;
	coord_t out_y;
	logic out_valid;
	logic out_stall;
	logic signed [OUT_W-1:0] src_x;
	logic signed [OUT_W-1:0] src_y;
	logic in_range;
	logic write_pixel;
	logic reuse_last_colour;

	// typed-in result riding along with the payload, sampled at acceptance
	logic pinned_on;
	source_word_t pinned_word;

	// shadow of the registers as written through the port
	dim_t sw_q = 1;
	dim_t sh_q = 1;
	dim_t dw_q = 1;
	dim_t dh_q = 1;
	logic [MODE_W-1:0] mode_q = MODE_PLAIN;

	// shadow of the curve stepping
	logic [CURVE_W-1:0] phase_q = '0;
	logic [CURVE_W-1:0] shift_q = '0;
	logic rising_q = 1'b1;

	source_word_t source_q[$];
	int fault_count = 0;

	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_off_req = 1'b0;

	plan_row_t plan [PLAN_ROWS];

	nearest_neighbor_scale_coordinates u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_x(out_x),
		.out_y(out_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.src_x(src_x),
		.src_y(src_y),
		.in_range(in_range),
		.write_pixel(write_pixel),
		.reuse_last_colour(reuse_last_colour)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAIL nearest_neighbor_scale_coordinates");
		$finish;
	end

	// zero counts as one, anything past MAX_DIM as MAX_DIM
	function automatic longint eff_dim(dim_t v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_coord(longint v);
		if (v > OUT_MAX)
			v = OUT_MAX;
		if (v < OUT_MIN)
			v = OUT_MIN;
		return OUT_W'(v);
	endfunction

	// Source pixel for one output pixel. All quotients are (num + den/2)/den in
	// doubled form, so trunc(v + 1/2) is one signed divide toward zero.
	// Advances the curve state as a side effect.
	function automatic source_word_t nearest_source(coord_t cx, coord_t cy);
		longint x, y, sw, sh, dw, dh, px, py, den, s;
		source_word_t w;
		logic hit;
		x = cx;
		y = cy;
		sw = eff_dim(sw_q);
		sh = eff_dim(sh_q);
		dw = eff_dim(dw_q);
		dh = eff_dim(dh_q);
		// (0,0) restarts the curve in any mode, before the pixel is mapped
		if (x == 0 && y == 0) begin
			phase_q = '0;
			shift_q = '0;
			rising_q = 1'b1;
		end
		py = (2 * y * sh + dh) / (2 * dh);
		case (mode_q)
		MODE_MIRROR: begin
			px = (2 * (dw - 1) * dw - 2 * x * sw + dw) / (2 * dw);
			py = (2 * (dh - 1) * dh - 2 * y * sh + dh) / (2 * dh);
		end
		MODE_CURVE: begin
			s = shift_q;
			den = 2 * dw - 1 + s;
			px = (2 * x * (sw + x - s) + den) / (2 * den);
		end
		default: begin
			px = (2 * x * sw + dw) / (2 * dw);
		end
		endcase
		// range is judged before saturation
		hit = px >= 0 && px < sw && py >= 0 && py < sh;
		w.sx = clamp_coord(px);
		w.sy = clamp_coord(py);
		w.inr = hit;
		w.wr = mode_q == MODE_CURVE || hit;
		w.reuse = mode_q == MODE_CURVE && !hit;
		// shift steps after the last pixel of every fourth row
		if (mode_q == MODE_CURVE && x == dw - 1 && y % 4 == 0) begin
			phase_q = phase_q + CURVE_STEP;
			shift_q = rising_q ? phase_q : CURVE_LIMIT - phase_q;
			if (phase_q >= CURVE_LIMIT) begin
				phase_q = phase_q - CURVE_LIMIT;
				rising_q = !rising_q;
			end
		end
		return w;
	endfunction

	function automatic void check_field(string what, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fault_count++;
		end
	endfunction

	// Register shadow, prediction at input acceptance, and checking at output
	// acceptance. Everything is sampled on the edge, inputs are driven by NBA.
	always @(posedge clk) begin
		source_word_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
				REG_SRC_WIDTH: sw_q = cfg_data;
				REG_SRC_HEIGHT: sh_q = cfg_data;
				REG_DST_WIDTH: dw_q = cfg_data;
				REG_DST_HEIGHT: dh_q = cfg_data;
				REG_WARP_MODE: mode_q = cfg_data[MODE_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				// predictor always runs so the curve state stays in step
				want = nearest_source(out_x, out_y);
				source_q.push_back(pinned_on ? pinned_word : want);
			end
			if (out_valid && !out_stall) begin
				if (source_q.size() == 0) begin
					$display("%0t: result word with nothing expected, actual %0d %0d %b%b%b",
						$time, src_x, src_y, in_range, write_pixel, reuse_last_colour);
					fault_count++;
				end else begin
					want = source_q.pop_front();
					check_field("src_x", $signed(want.sx), src_x);
					check_field("src_y", $signed(want.sy), src_y);
					check_field("in_range", want.inr, in_range);
					check_field("write_pixel", want.wr, write_pixel);
					check_field("reuse_last_colour", want.reuse, reuse_last_colour);
				end
			end
		end
	end

	// Result side: a random stall before each word, or one long hold-off on
	// request so the block backs up and stalls its input.
	initial begin
		int stall_cycles;
		forever begin
			if (hold_off_req) begin
				stall_cycles = LONG_HOLD;
				hold_off_req = 1'b0;
			end else begin
				stall_cycles = recv_idle_on ? $urandom_range(0, 4) : 0;
			end
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Offer one word after a random gap and return on the accepting edge.
	// Valid stays high into the next call so back-to-back words get one NBA.
	task automatic send_word(coord_t x, coord_t y, logic pinned, source_word_t pin);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		out_x <= x;
		out_y <= y;
		pinned_on <= pinned;
		pinned_word <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (source_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, dim_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// block must be idle; a stray write to the unused index now and then
	task automatic program_scale(dim_t sw, dim_t sh, dim_t dw, dim_t dh, dim_t mode_word);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, dim_t'($urandom_range(0, 8191)));
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_WARP_MODE, mode_word);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic plan_row_t setup_row(dim_t sw, dim_t sh, dim_t dw, dim_t dh,
			logic [MODE_W-1:0] mode);
		plan_row_t r;
		r = '0;
		r.setup = 1'b1;
		r.sw = sw;
		r.sh = sh;
		r.dw = dw;
		r.dh = dh;
		r.mode = mode;
		return r;
	endfunction

	function automatic plan_row_t word_row(coord_t x, coord_t y);
		plan_row_t r;
		r = '0;
		r.x = x;
		r.y = y;
		return r;
	endfunction

	function automatic plan_row_t pinned_row(coord_t x, coord_t y, int sx, int sy,
			logic inr, logic wr, logic reuse);
		plan_row_t r;
		r = word_row(x, y);
		r.pinned = 1'b1;
		r.want = '{OUT_W'(sx), OUT_W'(sy), inr, wr, reuse};
		return r;
	endfunction

	// mostly small sizes so rows end often, with edge values mixed in
	function automatic dim_t pick_dim();
		case ($urandom_range(0, 9))
		6: return dim_t'($urandom_range(13, 300));
		7: return ($urandom_range(0, 1) == 0) ? dim_t'(0) : dim_t'(MAX_DIM);
		8: return dim_t'($urandom_range(MAX_DIM + 1, 8191));
		9: return dim_t'($urandom_range(0, 8191));
		default: return dim_t'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		default: return coord_t'($urandom_range(0, 4095));
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		longint rx, ry, dwe, dhe;
		logic [MODE_W-1:0] mode;
		dim_t mode_word;
		coord_t x, y;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		out_x <= '0;
		out_y <= '0;
		pinned_on <= 1'b0;
		pinned_word <= '0;

		// Directed plan. Reset sizes are all one, so the map is the identity
		// and only (0,0) is in range.
		plan[0] = pinned_row(0, 0, 0, 0, 1, 1, 0);
		plan[1] = pinned_row(4095, 4095, 4095, 4095, 0, 0, 0);
		plan[2] = pinned_row(4095, 0, 4095, 0, 0, 0, 0);
		plan[3] = pinned_row(0, 4095, 0, 4095, 0, 0, 0);
		// 4096:1 downscale: saturation high, and exactly sw is out of range
		plan[4] = setup_row(4096, 4096, 1, 1, MODE_PLAIN);
		plan[5] = pinned_row(0, 0, 0, 0, 1, 1, 0);
		plan[6] = pinned_row(2, 3, OUT_MAX, OUT_MAX, 0, 0, 0);
		plan[7] = pinned_row(1, 0, 4096, 0, 0, 0, 0);
		// zero sizes count as one; unused mode acts plain
		plan[8] = setup_row(0, 0, 0, 0, MODE_UNUSED);
		plan[9] = pinned_row(0, 0, 0, 0, 1, 1, 0);
		plan[10] = pinned_row(1, 1, 1, 1, 0, 0, 0);
		// oversize clamps to MAX_DIM; mirror of a 1:1 map is 4095 - x
		plan[11] = setup_row(8191, 5000, 8191, 4097, MODE_MIRROR);
		plan[12] = pinned_row(0, 0, 4095, 4095, 1, 1, 0);
		plan[13] = pinned_row(4095, 4095, 0, 0, 1, 1, 0);
		// mirror going negative: -4095.5 truncates toward zero, then saturation low
		plan[14] = setup_row(4096, 1, 1, 1, MODE_MIRROR);
		plan[15] = pinned_row(1, 0, -4095, 0, 0, 0, 0);
		plan[16] = pinned_row(4095, 0, OUT_MIN, 0, 0, 0, 0);
		// curve warp: row ends at multiples of four walk the shift up to the
		// limit and back, far columns reuse the last color, (0,0) restarts
		plan[17] = setup_row(8, 8, 4, 4, MODE_CURVE);
		plan[18] = word_row(0, 0);
		plan[19] = word_row(3, 0);
		plan[20] = word_row(1, 1);
		plan[21] = word_row(3, 4);
		plan[22] = word_row(2, 5);
		plan[23] = word_row(3, 8);
		plan[24] = word_row(3, 12);
		plan[25] = word_row(3, 16);
		plan[26] = word_row(4095, 20);
		plan[27] = word_row(0, 0);
		plan[28] = word_row(3, 3);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < PLAN_ROWS; n++) begin
			if (plan[n].setup) begin
				drain_results();
				program_scale(plan[n].sw, plan[n].sh, plan[n].dw, plan[n].dh,
					dim_t'(plan[n].mode));
			end else begin
				send_word(plan[n].x, plan[n].y, plan[n].pinned, plan[n].want);
			end
		end

		// Random phases: each drains, picks new sizes and mode, then walks a
		// raster from (0,0) with jumps to row ends and random noise words.
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			if (phase == 0) begin
				program_scale(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, dim_t'(MODE_CURVE));
			end else begin
				case ($urandom_range(0, 9))
				5, 6: mode = MODE_PLAIN;
				7, 8: mode = MODE_MIRROR;
				9: mode = MODE_UNUSED;
				default: mode = MODE_CURVE;
				endcase
				// upper bits of the mode word are don't-care
				mode_word = ($urandom_range(0, 3) == 0) ?
					{11'($urandom_range(0, 2047)), mode} : dim_t'(mode);
				program_scale(pick_dim(), pick_dim(), pick_dim(), pick_dim(), mode_word);
			end
			send_idle_on = $urandom_range(0, 3) != 0;
			recv_idle_on = $urandom_range(0, 3) != 0;
			dwe = eff_dim(dw_q);
			dhe = eff_dim(dh_q);
			rx = 0;
			ry = 0;
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (phase == 2 && n == 30)
					hold_off_req = 1'b1;
				case ($urandom_range(0, 9))
				8, 9: begin
					x = pick_coord();
					y = pick_coord();
				end
				default: begin
					if ($urandom_range(0, 7) == 0)
						rx = dwe - 1;
					x = coord_t'(rx);
					y = coord_t'(ry);
					rx++;
					if (rx == dwe) begin
						rx = 0;
						ry++;
						if (ry == dhe)
							ry = 0;
					end
				end
				endcase
				send_word(x, y, 1'b0, '0);
			end
		end

		drain_results();
		repeat (2 * LATENCY) @(posedge clk);
		if (source_q.size() != 0) begin
			$display("%0t: %0d expected result words never arrived", $time, source_q.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("PASS nearest_neighbor_scale_coordinates");
		else
			$display("FAIL nearest_neighbor_scale_coordinates");
		$finish;
	end

endmodule
